>>> hdl/ipv4_header_checker_unit_assert.svh
// Assertion macros for the IPv4 header checker unit.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef IPV4_HEADER_CHECKER_UNIT_ASSERT_SVH
`define IPV4_HEADER_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPV4HC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPV4HC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ipv4hc_pkg.sv
// Shared types, constants and functions of the IPv4 header checker.
// No dependencies.
`timescale 1ns / 1ps

package ipv4hc_pkg;

  typedef enum logic [2:0] {
    VERDICT_LOCAL      = 3'd0,
    VERDICT_NOT_FOR_US = 3'd1,
    VERDICT_BAD_CSUM   = 3'd2,
    VERDICT_OPTIONS    = 3'd3,
    VERDICT_TTL_EXPIRED = 3'd4
  } verdict_t;

  localparam logic [3:0]  PLAIN_IHL      = 4'd5;
  localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;
  localparam logic [4:0]  WORD_TTL_PROTO = 5'd4;
  localparam logic [4:0]  WORD_SRC_HI    = 5'd6;
  localparam logic [4:0]  WORD_SRC_LO    = 5'd7;
  localparam logic [4:0]  WORD_DST_HI    = 5'd8;
  localparam logic [4:0]  WORD_DST_LO    = 5'd9;

  typedef struct packed {
    logic        valid;
    logic [15:0] header_word;
    logic        first_word;
  } stage_item_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[15:0] + {15'd0, sum[16]};
  endfunction

endpackage

>>> hdl/ipv4hc_if.sv
// Stream interfaces of the IPv4 header checker: header words in, verdicts out.
// Depends on ipv4hc_pkg for the verdict type.
`timescale 1ns / 1ps

interface ipv4hc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic        first_word;

  modport source (output valid, output header_word, output first_word, input ready);
  modport sink (input valid, input header_word, input first_word, output ready);
endinterface

interface ipv4hc_out_if;
  logic                valid;
  logic                ready;
  ipv4hc_pkg::verdict_t verdict;
  logic [7:0]          protocol_number;
  logic [31:0]         source_address;
  logic [31:0]         dest_address;

  modport source (output valid, output verdict, output protocol_number,
                  output source_address, output dest_address, input ready);
  modport sink (input valid, input verdict, input protocol_number,
                input source_address, input dest_address, output ready);
endinterface

>>> hdl/ipv4hc_input_reg.sv
// Input register of the IPv4 header checker.
// Depends on ipv4hc_pkg and ipv4hc_in_if.
`timescale 1ns / 1ps

module ipv4hc_input_reg (
  input  logic                    clk,
  input  logic                    rst,
  ipv4hc_in_if.sink               words,
  input  logic                    advance,
  output ipv4hc_pkg::stage_item_t stage
);

  ipv4hc_pkg::stage_item_t item;

  assign words.ready = !item.valid || advance;
  assign stage       = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (words.ready) begin
      item.valid <= words.valid;
    end
    if (words.ready && words.valid) begin
      item.header_word <= words.header_word;
      item.first_word  <= words.first_word;
    end
  end

endmodule

>>> hdl/ipv4hc_header_core.sv
// Header state, checksum accumulation, verdict and result register.
// Depends on ipv4hc_pkg and ipv4hc_out_if.
`timescale 1ns / 1ps

module ipv4hc_header_core (
  input  logic                    clk,
  input  logic                    rst,
  input  ipv4hc_pkg::stage_item_t stage,
  input  logic [31:0]             local_address,
  output logic                    advance,
  ipv4hc_out_if.source            results
);

  logic [4:0]  word_count, word_count_next;
  logic [15:0] checksum_acc, checksum_acc_next;
  logic [3:0]  header_len_words, header_len_words_next;
  logic [7:0]  ttl_value, ttl_value_next;
  logic [7:0]  proto_value, proto_value_next;
  logic [31:0] src_addr_reg, src_addr_reg_next;
  logic [31:0] dst_addr_reg, dst_addr_reg_next;
  logic        verdict_done, verdict_done_next;

  logic                 active;
  logic                 emit;
  ipv4hc_pkg::verdict_t verdict_next;

  logic                 out_valid;
  ipv4hc_pkg::verdict_t out_verdict;
  logic [7:0]           out_protocol;
  logic [31:0]          out_source;
  logic [31:0]          out_dest;

  assign advance = !out_valid || results.ready;
  assign active  = stage.valid && advance;

  always_comb begin
    word_count_next       = word_count;
    checksum_acc_next     = checksum_acc;
    header_len_words_next = header_len_words;
    ttl_value_next        = ttl_value;
    proto_value_next      = proto_value;
    src_addr_reg_next     = src_addr_reg;
    dst_addr_reg_next     = dst_addr_reg;
    verdict_done_next     = verdict_done;
    emit                  = 1'b0;
    verdict_next          = ipv4hc_pkg::VERDICT_BAD_CSUM;

    if (stage.first_word) begin
      word_count_next       = 5'd0;
      checksum_acc_next     = 16'd0;
      ttl_value_next        = 8'd0;
      proto_value_next      = 8'd0;
      src_addr_reg_next     = 32'd0;
      dst_addr_reg_next     = 32'd0;
      header_len_words_next = stage.header_word[11:8];
      verdict_done_next     = 1'b0;
    end

    if (stage.first_word && header_len_words_next == 4'd0) begin
      emit              = 1'b1;
      verdict_done_next = 1'b1;
    end else if (!verdict_done_next) begin
      checksum_acc_next = ipv4hc_pkg::ones_add(checksum_acc_next, stage.header_word);
      case (word_count_next)
        ipv4hc_pkg::WORD_TTL_PROTO: begin
          ttl_value_next   = stage.header_word[15:8];
          proto_value_next = stage.header_word[7:0];
        end
        ipv4hc_pkg::WORD_SRC_HI: src_addr_reg_next[31:16] = stage.header_word;
        ipv4hc_pkg::WORD_SRC_LO: src_addr_reg_next[15:0]  = stage.header_word;
        ipv4hc_pkg::WORD_DST_HI: dst_addr_reg_next[31:16] = stage.header_word;
        ipv4hc_pkg::WORD_DST_LO: dst_addr_reg_next[15:0]  = stage.header_word;
        default: begin
        end
      endcase
      word_count_next = word_count_next + 5'd1;

      if (word_count_next == {header_len_words_next, 1'b0}) begin
        emit              = 1'b1;
        verdict_done_next = 1'b1;
        if (checksum_acc_next != ipv4hc_pkg::CSUM_GOOD) begin
          verdict_next = ipv4hc_pkg::VERDICT_BAD_CSUM;
        end else if (header_len_words_next != ipv4hc_pkg::PLAIN_IHL) begin
          verdict_next = ipv4hc_pkg::VERDICT_OPTIONS;
        end else if (ttl_value_next == 8'd0) begin
          verdict_next = ipv4hc_pkg::VERDICT_TTL_EXPIRED;
        end else if (dst_addr_reg_next == local_address) begin
          verdict_next = ipv4hc_pkg::VERDICT_LOCAL;
        end else begin
          verdict_next = ipv4hc_pkg::VERDICT_NOT_FOR_US;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count       <= 5'd0;
      checksum_acc     <= 16'd0;
      header_len_words <= 4'd0;
      ttl_value        <= 8'd0;
      proto_value      <= 8'd0;
      src_addr_reg     <= 32'd0;
      dst_addr_reg     <= 32'd0;
      verdict_done     <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (active) begin
        word_count       <= word_count_next;
        checksum_acc     <= checksum_acc_next;
        header_len_words <= header_len_words_next;
        ttl_value        <= ttl_value_next;
        proto_value      <= proto_value_next;
        src_addr_reg     <= src_addr_reg_next;
        dst_addr_reg     <= dst_addr_reg_next;
        verdict_done     <= verdict_done_next;
      end
      if (advance) begin
        out_valid <= active && emit;
      end
    end
    if (active && emit) begin
      out_verdict  <= verdict_next;
      out_protocol <= proto_value_next;
      out_source   <= src_addr_reg_next;
      out_dest     <= dst_addr_reg_next;
    end
  end

  assign results.valid           = out_valid;
  assign results.verdict         = out_verdict;
  assign results.protocol_number = out_protocol;
  assign results.source_address  = out_source;
  assign results.dest_address    = out_dest;

endmodule

>>> hdl/ipv4_header_checker_unit.sv
// Top level of the IPv4 header checker: local address register and pipeline.
// Depends on ipv4hc_pkg, ipv4hc_if, ipv4hc_input_reg, ipv4hc_header_core
// and ipv4_header_checker_unit_assert.svh.
//
// Header words enter on the words channel, one 16-bit network-order word per
// transfer, with first_word set on the first word of each header. After the
// last of the IHL*2 words, one verdict with the protocol and both addresses
// leaves on the results channel; words after that without first_word are
// dropped. A header length of zero gives a bad-checksum verdict at once.
// The address compared with the destination must be written through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
// The last header word passes through the input register and then the result
// register before its result is valid. Throughput is one word per cycle while
// the receiver takes results; the header core adds each word into the checksum
// with end-around carry.
// Reset clears the header state, empties both registers and sets the local
// address to zero. When the receiver stalls, the result register holds its
// item, the input register takes one more word only if it is empty, and ready
// then drops until the result is taken.
`timescale 1ns / 1ps

`include "ipv4_header_checker_unit_assert.svh"

module ipv4_header_checker_unit (
  input  logic         clk,
  input  logic         rst,
  ipv4hc_in_if.sink    words,
  ipv4hc_out_if.source results,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data
);

  logic [31:0]             local_address;
  logic                    advance;
  ipv4hc_pkg::stage_item_t stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= 32'd0;
    end else if (cfg_wr_en) begin
      local_address <= cfg_wr_data;
    end
  end

  ipv4hc_input_reg u_input_reg (
    .clk     (clk),
    .rst     (rst),
    .words   (words),
    .advance (advance),
    .stage   (stage)
  );

  ipv4hc_header_core u_header_core (
    .clk           (clk),
    .rst           (rst),
    .stage         (stage),
    .local_address (local_address),
    .advance       (advance),
    .results       (results)
  );

  `IPV4HC_ASSERT_IMP(a_stall_only_on_backpressure, !words.ready,
                     results.valid && !results.ready && stage.valid,
                     "input stalled without a held result and a held word")
  `IPV4HC_ASSERT_NXT(a_result_from_stage, !stage.valid && !results.valid,
                     !results.valid,
                     "result appeared without a word in the input register")

endmodule

>>> tb/sv/ipv4_header_verdict_monitor.sv
// Passive monitor for the IPv4 header checker: predicts one verdict per whole
// header from word transfers and local address writes, and compares results.
// Depends on ipv4hc_pkg and the stream interfaces in ipv4hc_if.
`timescale 1ns / 1ps

module ipv4_header_verdict_monitor (
  input  logic         clk,
  input  logic         rst,
  ipv4hc_in_if         words,
  ipv4hc_out_if        results,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  output int           mismatch_count,
  output int           results_pending,
  output int           verdicts_seen
);

  typedef struct packed {
    ipv4hc_pkg::verdict_t verdict;
    logic [7:0]           protocol;
    logic [31:0]          src;
    logic [31:0]          dst;
  } header_outcome_t;

  header_outcome_t outcome_q[$];

  logic [31:0] local_addr;
  logic [4:0]  word_idx;
  logic [15:0] csum;
  logic [3:0]  ihl;
  logic [7:0]  ttl;
  logic [7:0]  proto;
  logic [31:0] src;
  logic [31:0] dst;
  logic        awaiting_first;
  int          fails;
  int          seen;

  function automatic logic [15:0] fold_add16(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] t;
    t = 32'(a) + 32'(b);
    return t[15:0] + 16'(t[16]);
  endfunction

  task automatic post_outcome(input ipv4hc_pkg::verdict_t v);
    header_outcome_t o;
    o.verdict = v;
    o.protocol = proto;
    o.src = src;
    o.dst = dst;
    outcome_q.push_back(o);
    awaiting_first = 1'b1;
  endtask

  task automatic predict_word(input logic [15:0] w, input logic first);
    logic [4:0] idx;
    if (first) begin
      word_idx = '0;
      csum = '0;
      ttl = '0;
      proto = '0;
      src = '0;
      dst = '0;
      ihl = w[11:8];
      awaiting_first = 1'b0;
      if (ihl == 4'd0) begin
        post_outcome(ipv4hc_pkg::VERDICT_BAD_CSUM);
        return;
      end
    end else if (awaiting_first) begin
      return;
    end
    idx = word_idx;
    csum = fold_add16(csum, w);
    case (idx)
      ipv4hc_pkg::WORD_TTL_PROTO: begin
        ttl = w[15:8];
        proto = w[7:0];
      end
      ipv4hc_pkg::WORD_SRC_HI: src[31:16] = w;
      ipv4hc_pkg::WORD_SRC_LO: src[15:0] = w;
      ipv4hc_pkg::WORD_DST_HI: dst[31:16] = w;
      ipv4hc_pkg::WORD_DST_LO: dst[15:0] = w;
      default: ;
    endcase
    word_idx = word_idx + 5'd1;
    if (word_idx != {ihl, 1'b0}) return;
    if (csum != ipv4hc_pkg::CSUM_GOOD) post_outcome(ipv4hc_pkg::VERDICT_BAD_CSUM);
    else if (ihl != ipv4hc_pkg::PLAIN_IHL) post_outcome(ipv4hc_pkg::VERDICT_OPTIONS);
    else if (ttl == 8'd0) post_outcome(ipv4hc_pkg::VERDICT_TTL_EXPIRED);
    else if (dst == local_addr) post_outcome(ipv4hc_pkg::VERDICT_LOCAL);
    else post_outcome(ipv4hc_pkg::VERDICT_NOT_FOR_US);
  endtask

  always @(posedge clk) begin
    header_outcome_t want;
    header_outcome_t got;
    if (rst) begin
      outcome_q.delete();
      local_addr = '0;
      word_idx = '0;
      csum = '0;
      ihl = '0;
      ttl = '0;
      proto = '0;
      src = '0;
      dst = '0;
      awaiting_first = 1'b1;
      fails = 0;
      seen = 0;
    end else begin
      if (results.valid && results.ready) begin
        got.verdict = results.verdict;
        got.protocol = results.protocol_number;
        got.src = results.source_address;
        got.dst = results.dest_address;
        seen++;
        if (outcome_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result verdict=%0d proto=%02h src=%08h dst=%08h",
                   $time, got.verdict, got.protocol, got.src, got.dst);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch expected verdict=%0d proto=%02h src=%08h dst=%08h",
                     $time, want.verdict, want.protocol, want.src, want.dst);
            $display("%0t:          actual   verdict=%0d proto=%02h src=%08h dst=%08h",
                     $time, got.verdict, got.protocol, got.src, got.dst);
          end
        end
      end
      if (words.valid && words.ready) predict_word(words.header_word, words.first_word);
      if (cfg_wr_en) local_addr = cfg_wr_data;
    end
    mismatch_count <= fails;
    results_pending <= outcome_q.size();
    verdicts_seen <= seen;
  end

endmodule

>>> tb/sv/ipv4_header_checker_unit_test.sv
// Top of the IPv4 header checker testbench: clock, reset, header stimulus,
// result back-pressure and local address writes. Depends on ipv4hc_pkg,
// ipv4hc_if, ipv4_header_checker_unit and ipv4_header_verdict_monitor.
`timescale 1ns / 1ps

module ipv4_header_checker_unit_test;

  localparam int ITEM_TARGET = 1500;
  localparam int PHASES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  int          mismatch_count;
  int          results_pending;
  int          verdicts_seen;
  int          cycle_count;
  int          words_sent;
  int          headers_sent;
  logic [31:0] local_addr;
  bit          steady_sender;

  ipv4hc_in_if  words_if ();
  ipv4hc_out_if results_if ();

  ipv4_header_checker_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .words       (words_if),
    .results     (results_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ipv4_header_verdict_monitor u_monitor (
    .clk             (clk),
    .rst             (rst),
    .words           (words_if),
    .results         (results_if),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .verdicts_seen   (verdicts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int stall;
    results_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 6)) @(posedge clk);
    end
  end

  task automatic send_word(input logic [15:0] w, input logic first);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      words_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    words_if.valid <= 1'b1;
    words_if.header_word <= w;
    words_if.first_word <= first;
    @(posedge clk);
    while (!words_if.ready) @(posedge clk);
  endtask

  // Builds a header of the given length whose checksum is good unless a bit
  // is flipped; a cut ends the header early so the next first word restarts.
  task automatic send_header(input logic [3:0] ihl, input logic [7:0] ttl,
                             input logic [31:0] dst, input int cut, input bit flip);
    logic [15:0] hw [0:31];
    int unsigned acc;
    int n;
    int fix;
    int i;
    int nsent;
    n = (ihl == 4'd0) ? 1 : 2 * int'(ihl);
    for (i = 0; i < 32; i++) hw[i] = 16'($urandom);
    hw[0][11:8] = ihl;
    if ($urandom_range(0, 3) != 0) hw[0][15:12] = 4'd4;
    hw[4][15:8] = ttl;
    hw[8] = dst[31:16];
    hw[9] = dst[15:0];
    if (n > 1) begin
      fix = (n > 5) ? 5 : n - 1;
      hw[fix] = '0;
      acc = 0;
      for (i = 0; i < n; i++) acc += hw[i];
      acc = (acc & 32'hFFFF) + (acc >> 16);
      acc = (acc & 32'hFFFF) + (acc >> 16);
      hw[fix] = ~acc[15:0];
      if (flip) begin
        i = $urandom_range(1, n - 1);
        hw[i] = hw[i] ^ (16'd1 << $urandom_range(0, 15));
      end
    end
    nsent = (cut > 0 && cut < n) ? cut : n;
    for (i = 0; i < nsent; i++) send_word(hw[i], i == 0);
    words_sent += nsent;
    headers_sent++;
  endtask

  task automatic write_local_address(input logic [31:0] a);
    words_if.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    local_addr = a;
  endtask

  initial begin
    int phase;
    int target;
    int r;
    int n;
    logic [3:0] ihl;
    logic [7:0] ttl;
    logic [31:0] dst;
    logic [31:0] addr;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    words_if.valid = 1'b0;
    words_if.header_word = '0;
    words_if.first_word = 1'b0;
    words_sent = 0;
    headers_sent = 0;
    local_addr = '0;
    steady_sender = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_local_address(32'h0000_0000);
    send_word(16'hF0FF, 1'b1);
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_header(4'd1, 8'hFF, 32'hFFFF_FFFF, 0, 1'b0);
    send_header(4'd2, 8'h00, 32'h0000_0000, 0, 1'b1);
    send_header(4'd5, 8'h40, 32'h0000_0000, 3, 1'b0);
    send_header(4'd5, 8'hFF, 32'h0000_0000, 0, 1'b0);
    send_header(4'd5, 8'h00, 32'h0000_0000, 0, 1'b0);
    words_sent += 2;

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: addr = 32'hFFFF_FFFF;
        2: addr = 32'h0000_0000;
        4: addr = 32'h8000_0001;
        default: addr = $urandom;
      endcase
      write_local_address(addr);
      target = words_sent + ITEM_TARGET / PHASES;
      while (words_sent < target) begin
        steady_sender = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        if (r < 78) ihl = 4'd5;
        else if (r < 88) ihl = 4'($urandom_range(6, 15));
        else if (r < 96) ihl = 4'($urandom_range(1, 4));
        else ihl = 4'd0;
        ttl = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        r = $urandom_range(0, 99);
        if (r < 45) dst = local_addr;
        else if (r < 55) dst = local_addr ^ (32'd1 << $urandom_range(0, 31));
        else dst = $urandom;
        n = (ihl == 4'd0) ? 1 : 2 * int'(ihl);
        send_header(ihl, ttl, dst,
                    ($urandom_range(0, 99) < 8 && n > 1) ? $urandom_range(1, n - 1) : 0,
                    $urandom_range(0, 99) < 12);
        if ($urandom_range(0, 99) < 8) begin
          repeat ($urandom_range(1, 3)) send_word(16'($urandom), 1'b0);
        end
        if ($urandom_range(0, 99) < 4) begin
          send_word(16'($urandom), $urandom_range(0, 9) < 3);
        end
      end
    end

    words_if.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d verdicts from %0d headers (%0d header words) under %0d local addresses,",
             verdicts_seen, headers_sent, words_sent, PHASES + 1);
    $display("including restarts, short and option headers, bad checksums and ignored words.");
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> ipv4_header_checker_unit.f
+incdir+hdl
hdl/ipv4hc_pkg.sv
hdl/ipv4hc_if.sv
hdl/ipv4hc_input_reg.sv
hdl/ipv4hc_header_core.sv
hdl/ipv4_header_checker_unit.sv
tb/sv/ipv4_header_verdict_monitor.sv
tb/sv/ipv4_header_checker_unit_test.sv
